>>> rtl/core/arc_cache_replacement_defines.svh
// ----------------------------------------------------------------------------
// ARC assertion macros
// Shared property wrappers; the user scope supplies clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef ARC_CACHE_REPLACEMENT_DEFINES_SVH
`define ARC_CACHE_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define ARC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arc check failed");

// next-cycle implication
`define ARC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arc check failed");

`endif

>>> rtl/core/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Constants and types shared by the ARC replacement engine.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int MAX_CAPACITY = 16;
    localparam int PAGE_BITS    = 32;
    localparam int WORD_BITS    = 32;
    localparam int DIR_SIZE     = 2 * MAX_CAPACITY;
    localparam int IDX_W        = $clog2(DIR_SIZE);
    localparam int REC_W        = IDX_W;
    localparam int CNT_W        = $clog2(DIR_SIZE + 1);
    localparam int ENTRY_W      = PAGE_BITS + 2 + REC_W;
    localparam int CS_W         = 5;
    localparam int FOUND_W      = 3;
    localparam int ADDR_W       = 3;
    localparam int APB_W        = 32;
    localparam logic [CS_W-1:0] CS_RESET = CS_W'(8);

    localparam logic [ADDR_W-1:0] REG_CACHE_SIZE = '0;

    typedef enum logic [1:0] {
        L_T1 = 2'd0,
        L_T2 = 2'd1,
        L_B1 = 2'd2,
        L_B2 = 2'd3
    } list_t;

    typedef enum logic [FOUND_W-1:0] {
        FOUND_MISS = 3'd0,
        FOUND_T1   = 3'd1,
        FOUND_T2   = 3'd2,
        FOUND_B1   = 3'd3,
        FOUND_B2   = 3'd4
    } found_t;

endpackage

>>> rtl/core/arc_req_if.sv
// ----------------------------------------------------------------------------
// arc_req_if
// Request channel: one page number per word.
// ----------------------------------------------------------------------------
interface arc_req_if;
    logic                           valid;
    logic                           ready;
    logic [arc_pkg::WORD_BITS-1:0]  page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

>>> rtl/core/arc_rsp_if.sv
// ----------------------------------------------------------------------------
// arc_rsp_if
// Result channel: lookup outcome, target and evictions per word.
// ----------------------------------------------------------------------------
interface arc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [arc_pkg::FOUND_W-1:0]    found_in;
    logic [arc_pkg::CS_W-1:0]       target_after;
    logic                           demoted_valid;
    logic [arc_pkg::WORD_BITS-1:0]  demoted_page;
    logic                           dropped_valid;
    logic [arc_pkg::WORD_BITS-1:0]  dropped_page;

    modport source (output valid, output found_in, output target_after,
                    output demoted_valid, output demoted_page,
                    output dropped_valid, output dropped_page, input ready);
    modport sink   (input valid, input found_in, input target_after,
                    input demoted_valid, input demoted_page,
                    input dropped_valid, input dropped_page, output ready);
endinterface

>>> rtl/core/arc_ram.sv
// ----------------------------------------------------------------------------
// arc_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module arc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/arc_cache_replacement.sv
// ----------------------------------------------------------------------------
// arc_cache_replacement
// ARC replacement engine: directory RAM, list counters and a pass sequencer.
// ----------------------------------------------------------------------------
// One request at a time. Every request runs a scan over the 32-entry
// directory RAM (one entry per cycle), a divide on a
// ghost hit, then one to three list updates (drop, demote, move/insert),
// each a single read plus a read-modify-write sweep of the RAM.
// The result sits in an output register, so the next request is taken
// while it waits. cache_size is clamped to 1..16.
module arc_cache_replacement (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [arc_pkg::ADDR_W-1:0]   paddr,
    input  logic [arc_pkg::APB_W-1:0]    pwdata,
    output logic [arc_pkg::APB_W-1:0]    prdata,
    output logic                         pready,
    arc_req_if.sink                      req,
    arc_rsp_if.source                    rsp
);

    localparam int IDX_W = arc_pkg::IDX_W;
    localparam int REC_W = arc_pkg::REC_W;
    localparam int CNT_W = arc_pkg::CNT_W;
    localparam int SEQ_W = IDX_W + 1;
    localparam int CS_W  = arc_pkg::CS_W;
    localparam int PB    = arc_pkg::PAGE_BITS;
    localparam logic [SEQ_W-1:0] PASS_LAST = SEQ_W'(arc_pkg::DIR_SIZE);
    localparam logic [SEQ_W-1:0] PASS_END  = SEQ_W'(arc_pkg::DIR_SIZE + 1);
    localparam logic [SEQ_W-1:0] DIV_END   = SEQ_W'(CNT_W - 1);
    localparam logic [REC_W-1:0] REC_ONE   = REC_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(arc_pkg::DIR_SIZE);
    localparam logic [CS_W-1:0]  CAP       = CS_W'(arc_pkg::MAX_CAPACITY);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SCAN = 9'b000000010,
        S_DIV  = 9'b000000100,
        S_PLAN = 9'b000001000,
        S_NEXT = 9'b000010000,
        S_RDE  = 9'b000100000,
        S_LAT  = 9'b001000000,
        S_PASS = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        OP_DROP = 2'd0,
        OP_DEM  = 2'd1,
        OP_FIN  = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             has_dst;
        arc_pkg::list_t   dst;
        logic             is_new;
        op_kind_t         kind;
    } op_t;

    function automatic logic [CNT_W-1:0] cnt_sel(input arc_pkg::list_t l,
        input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b,
        input logic [CNT_W-1:0] c, input logic [CNT_W-1:0] d);
        logic [CNT_W-1:0] r;
        case (l)
            arc_pkg::L_T1: r = a;
            arc_pkg::L_T2: r = b;
            arc_pkg::L_B1: r = c;
            default:       r = d;
        endcase
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] idx_sel(input arc_pkg::list_t l,
        input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
        input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] d);
        logic [IDX_W-1:0] r;
        case (l)
            arc_pkg::L_T1: r = a;
            arc_pkg::L_T2: r = b;
            arc_pkg::L_B1: r = c;
            default:       r = d;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] cnt_upd(input logic [CNT_W-1:0] v,
        input logic dec, input logic inc);
        logic [CNT_W-1:0] r;
        r = v;
        if (dec && (r != '0))
        begin
            r = r - CNT_ONE;
        end
        if (inc)
        begin
            r = r + CNT_ONE;
        end
        return r;
    endfunction

    state_t                  state_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic                    pv_reg;
    logic [IDX_W-1:0]        pidx_reg;
    logic [CS_W-1:0]         cache_size_reg;
    logic [CS_W-1:0]         p_reg;
    logic [arc_pkg::DIR_SIZE-1:0] valid_reg;
    logic [CNT_W-1:0]        cnt_t1_reg, cnt_t2_reg, cnt_b1_reg, cnt_b2_reg;
    logic [PB-1:0]           req_tag_reg;
    logic                    hit_reg;
    logic [IDX_W-1:0]        hit_idx_reg;
    arc_pkg::list_t          hit_list_reg;
    logic [3:0]              lru_have_reg;
    logic [IDX_W-1:0]        lru_idx_reg [4];
    logic [REC_W-1:0]        lru_rec_reg [4];
    logic                    free_have_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic [CNT_W-1:0]        num_reg, den_reg, rem_reg, quo_reg;
    logic                    drop_pend_reg, dem_pend_reg, fin_pend_reg;
    op_t                     drop_op_reg, dem_op_reg, fin_op_reg, op_reg;
    logic                    old_valid_reg;
    arc_pkg::list_t          ol_reg;
    logic [REC_W-1:0]        or_reg;
    arc_pkg::found_t         found_reg;
    logic                    dem_v_reg, drp_v_reg;
    logic [PB-1:0]           dem_pg_reg, drp_pg_reg;
    logic                    out_v_reg;
    logic [arc_pkg::FOUND_W-1:0] out_found_reg;
    logic [CS_W-1:0]         out_p_reg;
    logic                    out_dem_v_reg, out_drp_v_reg;
    logic [arc_pkg::WORD_BITS-1:0] out_dem_pg_reg, out_drp_pg_reg;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_raddr;
    logic [arc_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [PB-1:0]           rtag;
    arc_pkg::list_t          rlist;
    logic [REC_W-1:0]        rrec, new_rec;

    logic [CS_W-1:0]         c_eff;
    logic [CNT_W-1:0]        c_ext, res_cnt, tot_cnt, q_one;
    logic [CS_W+1:0]         p_sum;
    logic [CS_W-1:0]         plan_p;
    arc_pkg::list_t          first_l, from_l;
    logic                    plan_dem, plan_drop, plan_fin, full;
    op_t                     plan_dem_op, plan_drop_op, plan_fin_op;
    arc_pkg::found_t         plan_found;
    logic [CNT_W-1:0]        rem_try;
    logic                    cfg_wr, out_take, out_load;

    arc_ram #(
        .WIDTH (arc_pkg::ENTRY_W),
        .DEPTH (arc_pkg::DIR_SIZE)
    ) u_dir_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pidx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == arc_pkg::REG_CACHE_SIZE);
    assign prdata = (paddr == arc_pkg::REG_CACHE_SIZE) ?
                    arc_pkg::APB_W'(cache_size_reg) : '0;

    assign req.ready = (state_reg == S_IDLE);
    assign out_take  = out_v_reg && rsp.ready;
    assign out_load  = (state_reg == S_DONE) && (!out_v_reg || rsp.ready);

    assign rsp.valid         = out_v_reg;
    assign rsp.found_in      = out_found_reg;
    assign rsp.target_after  = out_p_reg;
    assign rsp.demoted_valid = out_dem_v_reg;
    assign rsp.demoted_page  = out_dem_pg_reg;
    assign rsp.dropped_valid = out_drp_v_reg;
    assign rsp.dropped_page  = out_drp_pg_reg;

    assign rtag  = ram_rdata[arc_pkg::ENTRY_W-1 -: PB];
    assign rlist = arc_pkg::list_t'(ram_rdata[REC_W+1:REC_W]);
    assign rrec  = ram_rdata[REC_W-1:0];

    // directory sweep: read one entry, write back the renumbered entry
    always_comb
    begin
        case (state_reg)
            S_SCAN, S_PASS: ram_raddr = seq_reg[IDX_W-1:0];
            S_RDE:          ram_raddr = op_reg.idx;
            default:        ram_raddr = '0;
        endcase
        ram_we    = 1'b0;
        new_rec   = rrec;
        ram_wdata = ram_rdata;
        if ((state_reg == S_PASS) && pv_reg)
        begin
            if (pidx_reg == op_reg.idx)
            begin
                ram_we    = op_reg.has_dst;
                ram_wdata = {(op_reg.is_new ? req_tag_reg : rtag), op_reg.dst, {REC_W{1'b0}}};
            end
            else
            begin
                ram_we = valid_reg[pidx_reg];
                if (old_valid_reg && (rlist == ol_reg) && (rrec > or_reg))
                begin
                    new_rec = new_rec - REC_ONE;
                end
                if (op_reg.has_dst && (rlist == op_reg.dst))
                begin
                    new_rec = new_rec + REC_ONE;
                end
                ram_wdata = {rtag, rlist, new_rec};
            end
        end
    end

    assign rem_try = {rem_reg[CNT_W-2:0], num_reg[CNT_W-1]};

    // decision after scan and divide
    always_comb
    begin
        if (cache_size_reg == '0)
        begin
            c_eff = CS_W'(1);
        end
        else if (cache_size_reg > CAP)
        begin
            c_eff = CAP;
        end
        else
        begin
            c_eff = cache_size_reg;
        end
        c_ext   = CNT_W'(c_eff);
        res_cnt = cnt_t1_reg + cnt_t2_reg;
        tot_cnt = res_cnt + cnt_b1_reg + cnt_b2_reg;
        full    = (res_cnt >= c_ext);
        q_one   = (quo_reg == '0) ? CNT_ONE : quo_reg;
        p_sum   = (CS_W+2)'(p_reg) + (CS_W+2)'(q_one);
        plan_p  = p_reg;
        first_l = arc_pkg::L_T1;
        plan_found = arc_pkg::FOUND_MISS;
        plan_dem   = 1'b0;
        plan_drop  = 1'b0;
        plan_fin   = 1'b0;
        plan_dem_op  = '{idx: '0, has_dst: 1'b1, dst: arc_pkg::L_B1, is_new: 1'b0,
                         kind: OP_DEM};
        plan_drop_op = '{idx: '0, has_dst: 1'b0, dst: arc_pkg::L_B1, is_new: 1'b0,
                         kind: OP_DROP};
        plan_fin_op  = '{idx: hit_idx_reg, has_dst: 1'b1, dst: arc_pkg::L_T2,
                         is_new: 1'b0, kind: OP_FIN};
        if (hit_reg)
        begin
            plan_found = arc_pkg::found_t'({1'b0, hit_list_reg} + 3'd1);
            plan_fin   = 1'b1;
            if (hit_list_reg == arc_pkg::L_B1)
            begin
                plan_p  = (p_sum > (CS_W+2)'(c_eff)) ? c_eff : p_sum[CS_W-1:0];
                first_l = (cnt_t1_reg <= CNT_W'(plan_p)) ? arc_pkg::L_T2 : arc_pkg::L_T1;
            end
            else if (hit_list_reg == arc_pkg::L_B2)
            begin
                plan_p  = (CNT_W'(p_reg) > q_one) ? (p_reg - CS_W'(q_one)) : '0;
                first_l = (cnt_t1_reg >= CNT_W'(plan_p)) ? arc_pkg::L_T1 : arc_pkg::L_T2;
            end
        end
        else
        begin
            first_l = arc_pkg::L_T1;
        end
        from_l = first_l;
        if (cnt_sel(first_l, cnt_t1_reg, cnt_t2_reg, cnt_b1_reg, cnt_b2_reg) == '0)
        begin
            from_l = (first_l == arc_pkg::L_T1) ? arc_pkg::L_T2 : arc_pkg::L_T1;
        end
        plan_dem_op.idx = idx_sel(from_l, lru_idx_reg[0], lru_idx_reg[1],
                                  lru_idx_reg[2], lru_idx_reg[3]);
        plan_dem_op.dst = (from_l == arc_pkg::L_T1) ? arc_pkg::L_B1 : arc_pkg::L_B2;
        if (cnt_sel(from_l, cnt_t1_reg, cnt_t2_reg, cnt_b1_reg, cnt_b2_reg) != '0)
        begin
            plan_dem = hit_reg ? hit_list_reg[1] : full;
        end
        if (!hit_reg)
        begin
            if ((full && (tot_cnt >= {c_ext[CNT_W-2:0], 1'b0})) || (tot_cnt >= CNT_FULL))
            begin
                if (cnt_b1_reg != '0)
                begin
                    plan_drop        = 1'b1;
                    plan_drop_op.idx = lru_idx_reg[2];
                end
                else if (cnt_b2_reg != '0)
                begin
                    plan_drop        = 1'b1;
                    plan_drop_op.idx = lru_idx_reg[3];
                end
            end
            plan_fin_op.dst    = arc_pkg::L_T1;
            plan_fin_op.is_new = 1'b1;
            if (free_have_reg)
            begin
                plan_fin        = 1'b1;
                plan_fin_op.idx = free_idx_reg;
            end
            else if (plan_drop)
            begin
                plan_fin        = 1'b1;
                plan_fin_op.idx = plan_drop_op.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seq_reg        <= '0;
            pv_reg         <= 1'b0;
            cache_size_reg <= arc_pkg::CS_RESET;
            p_reg          <= '0;
            valid_reg      <= '0;
            cnt_t1_reg     <= '0;
            cnt_t2_reg     <= '0;
            cnt_b1_reg     <= '0;
            cnt_b2_reg     <= '0;
            drop_pend_reg  <= 1'b0;
            dem_pend_reg   <= 1'b0;
            fin_pend_reg   <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                cache_size_reg <= pwdata[CS_W-1:0];
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_v_reg <= 1'b0;
            end
            pv_reg <= ((state_reg == S_SCAN) || (state_reg == S_PASS)) &&
                      (seq_reg < PASS_LAST);
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        seq_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (seq_reg == PASS_END)
                    begin
                        seq_reg <= '0;
                        if (hit_reg && hit_list_reg[1])
                        begin
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            state_reg <= S_PLAN;
                        end
                    end
                    else
                    begin
                        seq_reg <= seq_reg + SEQ_W'(1);
                    end
                end
                S_DIV:
                begin
                    seq_reg <= seq_reg + SEQ_W'(1);
                    if (seq_reg == DIV_END)
                    begin
                        state_reg <= S_PLAN;
                    end
                end
                S_PLAN:
                begin
                    p_reg         <= plan_p;
                    drop_pend_reg <= plan_drop;
                    dem_pend_reg  <= plan_dem;
                    fin_pend_reg  <= plan_fin;
                    state_reg     <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (drop_pend_reg)
                    begin
                        drop_pend_reg <= 1'b0;
                        state_reg     <= S_RDE;
                    end
                    else if (dem_pend_reg)
                    begin
                        dem_pend_reg <= 1'b0;
                        state_reg    <= S_RDE;
                    end
                    else if (fin_pend_reg)
                    begin
                        fin_pend_reg <= 1'b0;
                        state_reg    <= S_RDE;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_RDE:
                begin
                    state_reg <= S_LAT;
                end
                S_LAT:
                begin
                    cnt_t1_reg <= cnt_upd(cnt_t1_reg,
                        valid_reg[op_reg.idx] && (rlist == arc_pkg::L_T1),
                        op_reg.has_dst && (op_reg.dst == arc_pkg::L_T1));
                    cnt_t2_reg <= cnt_upd(cnt_t2_reg,
                        valid_reg[op_reg.idx] && (rlist == arc_pkg::L_T2),
                        op_reg.has_dst && (op_reg.dst == arc_pkg::L_T2));
                    cnt_b1_reg <= cnt_upd(cnt_b1_reg,
                        valid_reg[op_reg.idx] && (rlist == arc_pkg::L_B1),
                        op_reg.has_dst && (op_reg.dst == arc_pkg::L_B1));
                    cnt_b2_reg <= cnt_upd(cnt_b2_reg,
                        valid_reg[op_reg.idx] && (rlist == arc_pkg::L_B2),
                        op_reg.has_dst && (op_reg.dst == arc_pkg::L_B2));
                    seq_reg   <= '0;
                    state_reg <= S_PASS;
                end
                S_PASS:
                begin
                    seq_reg <= seq_reg + SEQ_W'(1);
                    if (seq_reg == PASS_END)
                    begin
                        valid_reg[op_reg.idx] <= op_reg.has_dst;
                        state_reg <= S_NEXT;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload and per-request working registers
    always_ff @(posedge clk)
    begin
        pidx_reg <= seq_reg[IDX_W-1:0];
        if ((state_reg == S_IDLE) && req.valid)
        begin
            req_tag_reg   <= req.page[PB-1:0];
            hit_reg       <= 1'b0;
            lru_have_reg  <= '0;
            free_have_reg <= 1'b0;
            dem_v_reg     <= 1'b0;
            drp_v_reg     <= 1'b0;
            dem_pg_reg    <= '0;
            drp_pg_reg    <= '0;
        end
        if ((state_reg == S_SCAN) && pv_reg)
        begin
            if (valid_reg[pidx_reg])
            begin
                if (rtag == req_tag_reg)
                begin
                    hit_reg      <= 1'b1;
                    hit_idx_reg  <= pidx_reg;
                    hit_list_reg <= rlist;
                end
                for (int l = 0; l < 4; l++)
                begin
                    if ((rlist == arc_pkg::list_t'(l)) &&
                        (!lru_have_reg[l] || (rrec > lru_rec_reg[l])))
                    begin
                        lru_have_reg[l] <= 1'b1;
                        lru_idx_reg[l]  <= pidx_reg;
                        lru_rec_reg[l]  <= rrec;
                    end
                end
            end
            else if (!free_have_reg)
            begin
                free_have_reg <= 1'b1;
                free_idx_reg  <= pidx_reg;
            end
        end
        if ((state_reg == S_SCAN) && (seq_reg == PASS_END))
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            if (hit_list_reg == arc_pkg::L_B1)
            begin
                num_reg <= cnt_b2_reg;
                den_reg <= cnt_b1_reg;
            end
            else
            begin
                num_reg <= cnt_b1_reg + cnt_b2_reg - CNT_ONE;
                den_reg <= cnt_b2_reg;
            end
        end
        if (state_reg == S_DIV)
        begin
            num_reg <= {num_reg[CNT_W-2:0], 1'b0};
            if (rem_try >= den_reg)
            begin
                rem_reg <= rem_try - den_reg;
                quo_reg <= {quo_reg[CNT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[CNT_W-2:0], 1'b0};
            end
        end
        if (state_reg == S_PLAN)
        begin
            found_reg   <= plan_found;
            drop_op_reg <= plan_drop_op;
            dem_op_reg  <= plan_dem_op;
            fin_op_reg  <= plan_fin_op;
        end
        if (state_reg == S_NEXT)
        begin
            if (drop_pend_reg)
            begin
                op_reg <= drop_op_reg;
            end
            else if (dem_pend_reg)
            begin
                op_reg <= dem_op_reg;
            end
            else
            begin
                op_reg <= fin_op_reg;
            end
        end
        if (state_reg == S_LAT)
        begin
            old_valid_reg <= valid_reg[op_reg.idx];
            ol_reg        <= rlist;
            or_reg        <= rrec;
            if (op_reg.kind == OP_DROP)
            begin
                drp_v_reg  <= 1'b1;
                drp_pg_reg <= rtag;
            end
            else if (op_reg.kind == OP_DEM)
            begin
                dem_v_reg  <= 1'b1;
                dem_pg_reg <= rtag;
            end
        end
        if (out_load)
        begin
            out_found_reg  <= found_reg;
            out_p_reg      <= p_reg;
            out_dem_v_reg  <= dem_v_reg;
            out_drp_v_reg  <= drp_v_reg;
            out_dem_pg_reg <= arc_pkg::WORD_BITS'(dem_pg_reg);
            out_drp_pg_reg <= arc_pkg::WORD_BITS'(drp_pg_reg);
        end
    end

endmodule

>>> rtl/core/arc_checker.sv
// ----------------------------------------------------------------------------
// arc_checker
// Port-level checks on the ARC result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "arc_cache_replacement_defines.svh"

module arc_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                rsp_valid,
    input logic                                rsp_ready,
    input logic [arc_pkg::FOUND_W-1:0]         found_in,
    input logic [arc_pkg::CS_W-1:0]            target_after,
    input logic                                demoted_valid,
    input logic [arc_pkg::WORD_BITS-1:0]       demoted_page,
    input logic                                dropped_valid,
    input logic [arc_pkg::WORD_BITS-1:0]       dropped_page
);

    `ARC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(found_in) && $stable(demoted_page))
    `ARC_ASSERT_IMP(a_found_code, rsp_valid, found_in <= arc_pkg::FOUND_B2)
    `ARC_ASSERT_IMP(a_target_cap, rsp_valid, target_after <= arc_pkg::CS_W'(arc_pkg::MAX_CAPACITY))
    `ARC_ASSERT_IMP(a_hit_quiet, rsp_valid && ((found_in == arc_pkg::FOUND_T1) || (found_in == arc_pkg::FOUND_T2)), !demoted_valid && !dropped_valid)
    `ARC_ASSERT_IMP(a_pages_zero, rsp_valid, (demoted_valid || (demoted_page == '0)) && (dropped_valid || (dropped_page == '0)))

endmodule

bind arc_cache_replacement arc_checker u_arc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .found_in      (rsp.found_in),
    .target_after  (rsp.target_after),
    .demoted_valid (rsp.demoted_valid),
    .demoted_page  (rsp.demoted_page),
    .dropped_valid (rsp.dropped_valid),
    .dropped_page  (rsp.dropped_page)
);

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives page requests into the ARC replacement engine under random source and
// sink idling and several cache_size settings. Each result word is checked
// against a behavioral model of the four ARC lists; rows may fix found_in.
// ----------------------------------------------------------------------------
module tb_top;
    import arc_pkg::*;

    typedef struct packed {
        found_t          found;
        logic [CS_W-1:0] target;
        logic            dem_valid;
        logic [31:0]     dem_page;
        logic            drp_valid;
        logic [31:0]     drp_page;
    } outcome_t;

    typedef struct {
        logic [31:0] pg;
        int          want;
    } row_t;

    localparam int NUM_ROWS = 17;
    localparam int NO_WANT  = -1;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    arc_req_if page_req ();
    arc_rsp_if page_rsp ();

    arc_cache_replacement dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (page_req),
        .rsp     (page_rsp)
    );

    // list model
    logic [31:0]     m_tag   [DIR_SIZE];
    logic            m_valid [DIR_SIZE];
    list_t           m_list  [DIR_SIZE];
    int              m_rank  [DIR_SIZE];
    int              m_count [4];
    int              m_target;
    logic [CS_W-1:0] m_size;

    outcome_t outcome_q [$];
    int       errors;
    int       src_idle;
    int       snk_idle;
    int       hold_cycles;

    row_t dir_rows [NUM_ROWS] = '{
        '{32'h0000_0000, FOUND_MISS}, '{32'hFFFF_FFFF, FOUND_MISS},
        '{32'h0000_0000, FOUND_T1},   '{32'h0000_0000, FOUND_T2},
        '{32'hFFFF_FFFF, FOUND_T1},
        '{32'h0000_0001, FOUND_MISS}, '{32'h0000_0002, FOUND_MISS},
        '{32'h0000_0003, FOUND_MISS}, '{32'h0000_0004, FOUND_MISS},
        '{32'h0000_0005, FOUND_MISS}, '{32'h0000_0006, FOUND_MISS},
        '{32'h0000_0007, FOUND_MISS}, '{32'h0000_0008, FOUND_MISS},
        '{32'h0000_0001, FOUND_B1},   '{32'h0000_0002, FOUND_B1},
        '{32'h8000_0000, NO_WANT},    '{32'h7FFF_FFFF, NO_WANT}
    };

    function automatic int lru_slot(list_t l);
        int best;
        best = -1;
        for (int i = 0; i < DIR_SIZE; i++)
            if (m_valid[i] && m_list[i] == l && (best < 0 || m_rank[i] > m_rank[best]))
                best = i;
        return best;
    endfunction

    function automatic void unlink_slot(int k);
        for (int i = 0; i < DIR_SIZE; i++)
            if (m_valid[i] && m_list[i] == m_list[k] && m_rank[i] > m_rank[k])
                m_rank[i]--;
        m_valid[k] = 1'b0;
        if (m_count[m_list[k]] > 0)
            m_count[m_list[k]]--;
    endfunction

    function automatic void push_mru(int k, list_t l);
        for (int i = 0; i < DIR_SIZE; i++)
            if (m_valid[i] && m_list[i] == l)
                m_rank[i]++;
        m_valid[k] = 1'b1;
        m_list[k]  = l;
        m_rank[k]  = 0;
        m_count[l]++;
    endfunction

    function automatic logic demote_lru(list_t first, output logic [31:0] pg);
        list_t from;
        int    k;
        from = first;
        pg   = '0;
        if (m_count[from] == 0)
            from = (from == L_T1) ? L_T2 : L_T1;
        k = lru_slot(from);
        if (k < 0)
            return 1'b0;
        pg = m_tag[k];
        unlink_slot(k);
        push_mru(k, (from == L_T1) ? L_B1 : L_B2);
        return 1'b1;
    endfunction

    function automatic logic drop_ghost(output logic [31:0] pg);
        int k;
        pg = '0;
        k  = lru_slot(L_B1);
        if (k < 0)
            k = lru_slot(L_B2);
        if (k < 0)
            return 1'b0;
        pg = m_tag[k];
        unlink_slot(k);
        return 1'b1;
    endfunction

    function automatic outcome_t arc_predict(logic [31:0] pg);
        outcome_t o;
        int       c, k, step, res, tot;
        list_t    l;
        logic     full;
        o = '0;
        o.found = FOUND_MISS;
        c = (m_size < 1) ? 1 : (m_size > MAX_CAPACITY) ? MAX_CAPACITY : m_size;
        k = -1;
        for (int i = 0; i < DIR_SIZE; i++)
            if (k < 0 && m_valid[i] && m_tag[i] == pg)
                k = i;
        if (k >= 0) begin
            l = m_list[k];
            o.found = found_t'(l + 1);
            if (l == L_B1) begin
                step = m_count[L_B2] / m_count[L_B1];
                if (step < 1)
                    step = 1;
                m_target = (m_target + step > c) ? c : m_target + step;
                o.dem_valid = demote_lru((m_count[L_T1] <= m_target) ? L_T2 : L_T1,
                                         o.dem_page);
            end
            else if (l == L_B2) begin
                step = (m_count[L_B1] + m_count[L_B2] - 1) / m_count[L_B2];
                if (step < 1)
                    step = 1;
                m_target = (m_target > step) ? m_target - step : 0;
                o.dem_valid = demote_lru((m_count[L_T1] >= m_target) ? L_T1 : L_T2,
                                         o.dem_page);
            end
            unlink_slot(k);
            push_mru(k, L_T2);
        end
        else begin
            res  = m_count[L_T1] + m_count[L_T2];
            tot  = res + m_count[L_B1] + m_count[L_B2];
            full = (res >= c);
            if ((full && tot >= 2 * c) || tot >= DIR_SIZE)
                o.drp_valid = drop_ghost(o.drp_page);
            if (full)
                o.dem_valid = demote_lru(L_T1, o.dem_page);
            for (int i = 0; i < DIR_SIZE; i++)
                if (k < 0 && !m_valid[i])
                    k = i;
            if (k >= 0) begin
                m_tag[k] = pg;
                push_mru(k, L_T1);
            end
        end
        o.target = m_target[CS_W-1:0];
        return o;
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #60_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic write_size(input logic [CS_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CACHE_SIZE;
        pwdata  <= APB_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        m_size = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        wait (outcome_q.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_page(input logic [31:0] pg, input int want);
        outcome_t o;
        @(negedge clk);
        while ($urandom_range(99) < src_idle) begin
            page_req.valid <= 1'b0;
            page_req.page  <= $urandom;
            @(negedge clk);
        end
        page_req.valid <= 1'b1;
        page_req.page  <= pg;
        do
            @(posedge clk);
        while (!page_req.ready);
        o = arc_predict(pg);
        if (want != NO_WANT)
            o.found = found_t'(want);
        outcome_q.push_back(o);
    endtask

    // result sink
    initial begin
        page_rsp.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                page_rsp.ready <= 1'b0;
            end
            else
                page_rsp.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge clk) begin
        outcome_t want_o;
        outcome_t got;
        if (rst_n && page_rsp.valid && page_rsp.ready) begin
            got.found     = found_t'(page_rsp.found_in);
            got.target    = page_rsp.target_after;
            got.dem_valid = page_rsp.demoted_valid;
            got.dem_page  = page_rsp.demoted_page;
            got.drp_valid = page_rsp.dropped_valid;
            got.drp_page  = page_rsp.dropped_page;
            if (outcome_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: %p", got);
            end
            else begin
                want_o = outcome_q.pop_front();
                if (got.found !== want_o.found || got.target !== want_o.target ||
                    got.dem_valid !== want_o.dem_valid || got.dem_page !== want_o.dem_page ||
                    got.drp_valid !== want_o.drp_valid || got.drp_page !== want_o.drp_page)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p, got %p", want_o, got);
                end
            end
        end
    end

    initial begin
        logic [CS_W-1:0] sizes [7];
        logic [31:0]     pool  [$];
        logic [31:0]     pg;
        int              n;
        sizes = '{5'd8, 5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd12};
        errors      = 0;
        hold_cycles = 0;
        src_idle    = 15;
        snk_idle    = 88;
        n           = 0;
        m_size      = CS_RESET;
        m_target    = 0;
        for (int i = 0; i < DIR_SIZE; i++) begin
            m_valid[i] = 1'b0;
            m_tag[i]   = '0;
            m_list[i]  = L_T1;
            m_rank[i]  = 0;
        end
        for (int i = 0; i < 4; i++)
            m_count[i] = 0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        page_req.valid = 1'b0;
        page_req.page  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_page(dir_rows[i].pg, dir_rows[i].want);

        foreach (sizes[s]) begin
            @(negedge clk);
            page_req.valid <= 1'b0;
            drain();
            write_size(sizes[s]);
            pool.delete();
            for (int i = 0; i < 2 * MAX_CAPACITY + 4; i++)
                pool.push_back($urandom);
            for (int i = 0; i < 185; i++) begin
                if (n == 430) begin
                    src_idle = 88;
                    snk_idle = 15;
                end
                if (n == 860) begin
                    src_idle = 0;
                    snk_idle = 0;
                end
                if (n == 60)
                    hold_cycles = 600;
                if (n == 300) begin
                    @(negedge clk);
                    page_req.valid <= 1'b0;
                    wait (outcome_q.size() == 0);
                end
                if ($urandom_range(9) == 0)
                    pg = $urandom;
                else
                    pg = pool[$urandom_range(2 * ((sizes[s] == 0) ? 1 :
                              (sizes[s] > 16) ? 16 : sizes[s]) + 3)];
                send_page(pg, NO_WANT);
                n++;
            end
        end
        @(negedge clk);
        page_req.valid <= 1'b0;
        wait (outcome_q.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && outcome_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/arc_pkg.sv
rtl/core/arc_req_if.sv
rtl/core/arc_rsp_if.sv
rtl/core/arc_ram.sv
rtl/core/arc_cache_replacement.sv
rtl/core/arc_checker.sv
tb/tb_top.sv
